/* sv/phta_pkg.sv */
// ----------------------------------------------------------------------------
// phta_pkg
// shared types, register codes and constants of the pulse high time accumulator
// ----------------------------------------------------------------------------
package phta_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_INTERVAL     = 3'd0;
   localparam csr_index_type CSR_REJECT_LIMIT = 3'd1;
   localparam csr_index_type CSR_MIN_WIDTH    = 3'd2;
   localparam csr_index_type CSR_SPLIT_AGE    = 3'd3;
   localparam csr_index_type CSR_RELATIVE     = 3'd4;
   localparam csr_index_type CSR_COUNT_ENABLE = 3'd5;

   // register reset values
   localparam logic [31:0] INTERVAL_RESET     = 32'd60000000;
   localparam logic [31:0] REJECT_LIMIT_RESET = 32'd300000000;
   localparam logic [19:0] MIN_WIDTH_RESET    = 20'd17;
   localparam logic [31:0] SPLIT_AGE_RESET    = 32'd490000;

   // input action codes
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_POLL = 1'b1;

   // over-interval test: total * 100 > interval * 103
   localparam logic [6:0] OVER_NUM = 7'd103;
   localparam logic [6:0] OVER_DEN = 7'd100;

   // 256 * 1e6, frequency in 1/256 Hz from a count over microseconds
   localparam logic [27:0] FREQ_SCALE = 28'd256000000;

   localparam logic [16:0] FRAC_ONE = 17'h10000;
   localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;

   // shared divider, one quotient bit per step
   localparam int DIV_ITERS = 64;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_ITERS);

   typedef enum logic {
      DIV_FRAC = 1'b0,
      DIV_FREQ = 1'b1
   } div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        tick;
      logic        poll;
      logic        flags;
      logic        div_load;
      div_sel_type div_sel;
      logic        div_step;
      logic        out_load;
   } phta_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_free;
      logic relative_mode;
      logic count_enable;
      logic interval_zero;
   } phta_status_type;

endpackage

/* sv/phta_if.sv */
// ----------------------------------------------------------------------------
// phta channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface phta_req_if;
   logic valid;
   logic ready;
   logic action;
   logic pin_level;

   modport source (output valid, output action, output pin_level, input ready);
   modport sink   (input valid, input action, input pin_level, output ready);
endinterface

interface phta_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] width_us;
   logic        rejected;
   logic        over_interval;
   logic [16:0] fraction_q16;
   logic [31:0] pulse_total;
   logic [31:0] freq_q8;

   modport source (output valid, output width_us, output rejected, output over_interval,
                   output fraction_q16, output pulse_total, output freq_q8, input ready);
   modport sink   (input valid, input width_us, input rejected, input over_interval,
                   input fraction_q16, input pulse_total, input freq_q8, output ready);
endinterface

interface phta_csr_if import phta_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [31:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/phta_ctrl.sv */
// ----------------------------------------------------------------------------
// phta_ctrl
// sequencer for ticks, polls, the divider passes and the response load
// ----------------------------------------------------------------------------
module phta_ctrl import phta_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_action,
   output logic            req_ready,
   input  phta_status_type status,
   output phta_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_FLAGS   = 7'b0000010,
      S_FRAC_LD = 7'b0000100,
      S_FRAC    = 7'b0001000,
      S_FREQ_LD = 7'b0010000,
      S_FREQ    = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      frac_go, freq_go;

   assign frac_go = status.relative_mode & ~status.interval_zero;
   assign freq_go = status.count_enable & ~status.interval_zero;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_FRAC;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_action == ACTION_POLL) begin
               cmd.poll = 1'b1;
               state_in = S_FLAGS;
            end else if (req_valid) begin
               cmd.tick = 1'b1;
            end
         end
         S_FLAGS: begin
            cmd.flags = 1'b1;
            if (frac_go) state_in = S_FRAC_LD;
            else if (freq_go) state_in = S_FREQ_LD;
            else state_in = S_DONE;
         end
         S_FRAC_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_FRAC;
            state_in     = S_FRAC;
         end
         S_FRAC: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = freq_go ? S_FREQ_LD : S_DONE;
         end
         S_FREQ_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_FREQ;
            state_in     = S_FREQ;
         end
         S_FREQ: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* sv/phta_dp.sv */
// ----------------------------------------------------------------------------
// phta_dp
// timebase, edge capture, accumulators, poll arithmetic, divider and registers
// ----------------------------------------------------------------------------
module phta_dp import phta_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  phta_cmd_type    cmd,
   output phta_status_type status,
   input  logic            req_pin_level,
   input  logic            csr_write,
   input  csr_index_type   csr_index,
   input  logic [31:0]     csr_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic [31:0]     rsp_width_us,
   output logic            rsp_rejected,
   output logic            rsp_over_interval,
   output logic [16:0]     rsp_fraction_q16,
   output logic [31:0]     rsp_pulse_total,
   output logic [31:0]     rsp_freq_q8
);

   // compare width covering both the time stamps and the 32-bit registers
   localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   // configuration
   logic [31:0] interval_ff, reject_limit_ff, split_age_ff;
   logic [19:0] min_width_ff;
   logic        relative_ff, count_en_ff;

   // measurement state
   logic [TIME_WIDTH-1:0] time_now_ff, rise_stamp_ff;
   logic                  level_prev_ff;
   logic [31:0]           width_total_ff, pulse_tally_ff;

   // poll working registers
   logic [31:0] poll_total_ff, ptot_ff, width_ff, freq_ff;
   logic [16:0] frac_ff;
   logic        over_ff, rej_ff;
   logic [59:0] prod_ff;

   // divider
   logic [31:0]              rem_ff;
   logic [63:0]              quo_ff;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   div_sel_type              sel_ff;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] out_width_ff, out_ptot_ff, out_freq_ff;
   logic [16:0] out_frac_ff;
   logic        out_rej_ff, out_over_ff;

   // tick path: edges are stamped with the advanced time
   logic [TIME_WIDTH-1:0] time_next, tick_w;
   logic [CW:0]           tick_sum;
   logic                  tick_long;

   assign time_next = time_now_ff + TIME_WIDTH'(1);
   assign tick_w    = time_next - rise_stamp_ff;
   assign tick_long = CW'(tick_w) > CW'(min_width_ff);
   assign tick_sum  = (CW+1)'(width_total_ff) + (CW+1)'(tick_w);

   // poll path: split of a long pulse still high
   logic [TIME_WIDTH-1:0] age;
   logic                  split;
   logic [CW:0]           poll_sum;
   logic [31:0]           poll_sat;

   assign age      = time_now_ff - rise_stamp_ff;
   assign split    = (CW'(age) > CW'(split_age_ff)) && req_pin_level;
   assign poll_sum = (CW+1)'(width_total_ff) + (split ? (CW+1)'(age) : '0);
   assign poll_sat = (|poll_sum[CW:32]) ? U32_MAX : poll_sum[31:0];

   // flag stage
   logic [38:0] over_lhs, over_rhs;
   logic        rej_now;
   logic [31:0] width_fin;

   assign over_lhs  = 39'(poll_total_ff) * 39'(OVER_DEN);
   assign over_rhs  = 39'(interval_ff) * 39'(OVER_NUM);
   assign rej_now   = poll_total_ff > reject_limit_ff;
   assign width_fin = rej_now ? 32'd0 : poll_total_ff;

   // restoring divider step
   logic [32:0] rem_shift;
   logic        q_bit;
   logic [32:0] rem_diff;
   logic [63:0] q_next;

   assign rem_shift = {rem_ff, quo_ff[63]};
   assign q_bit     = rem_shift >= {1'b0, interval_ff};
   assign rem_diff  = rem_shift - {1'b0, interval_ff};
   assign q_next    = {quo_ff[62:0], q_bit};

   // configuration writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff     <= INTERVAL_RESET;
         reject_limit_ff <= REJECT_LIMIT_RESET;
         min_width_ff    <= MIN_WIDTH_RESET;
         split_age_ff    <= SPLIT_AGE_RESET;
         relative_ff     <= 1'b0;
         count_en_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INTERVAL:     interval_ff     <= csr_data;
            CSR_REJECT_LIMIT: reject_limit_ff <= csr_data;
            CSR_MIN_WIDTH:    min_width_ff    <= csr_data[19:0];
            CSR_SPLIT_AGE:    split_age_ff    <= csr_data;
            CSR_RELATIVE:     relative_ff     <= csr_data[0];
            CSR_COUNT_ENABLE: count_en_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff    <= '0;
         rise_stamp_ff  <= '0;
         level_prev_ff  <= 1'b0;
         width_total_ff <= '0;
         pulse_tally_ff <= '0;
      end else if (cmd.tick) begin
         time_now_ff   <= time_next;
         level_prev_ff <= req_pin_level;
         if (req_pin_level && !level_prev_ff) begin
            rise_stamp_ff <= time_next;
         end else if (!req_pin_level && level_prev_ff && tick_long) begin
            width_total_ff <= (|tick_sum[CW:32]) ? U32_MAX : tick_sum[31:0];
            if (~&pulse_tally_ff) pulse_tally_ff <= pulse_tally_ff + 32'd1;
         end
      end else if (cmd.poll) begin
         width_total_ff <= '0;
         if (split) rise_stamp_ff <= time_now_ff;
         if (count_en_ff) pulse_tally_ff <= '0;
      end
   end

   // poll arithmetic and divider
   always_ff @(posedge clock) begin
      if (cmd.poll) begin
         poll_total_ff <= poll_sat;
         ptot_ff       <= count_en_ff ? pulse_tally_ff : 32'd0;
      end
      if (cmd.flags) begin
         over_ff  <= over_lhs > over_rhs;
         rej_ff   <= rej_now;
         width_ff <= width_fin;
         prod_ff  <= 60'(ptot_ff) * 60'(FREQ_SCALE);
         // zero interval and disabled cases settled here, the divider overwrites
         frac_ff  <= (relative_ff && interval_ff == 32'd0 && width_fin != 32'd0)
                     ? FRAC_ONE : 17'd0;
         freq_ff  <= (count_en_ff && interval_ff == 32'd0 && ptot_ff != 32'd0)
                     ? U32_MAX : 32'd0;
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= (cmd.div_sel == DIV_FRAC) ? {16'd0, width_ff, 16'd0} : {4'd0, prod_ff};
         cnt_ff <= DIV_CNT_WIDTH'(DIV_ITERS - 1);
         sel_ff <= cmd.div_sel;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_diff[31:0] : rem_shift[31:0];
         quo_ff <= q_next;
         cnt_ff <= cnt_ff - DIV_CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            if (sel_ff == DIV_FRAC) begin
               frac_ff <= (q_next > 64'(FRAC_ONE)) ? FRAC_ONE : q_next[16:0];
            end else begin
               freq_ff <= (|q_next[63:32]) ? U32_MAX : q_next[31:0];
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset)             rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)    rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_width_ff <= width_ff;
         out_rej_ff   <= rej_ff;
         out_over_ff  <= over_ff;
         out_frac_ff  <= frac_ff;
         out_ptot_ff  <= ptot_ff;
         out_freq_ff  <= freq_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_width_us      = out_width_ff;
   assign rsp_rejected      = out_rej_ff;
   assign rsp_over_interval = out_over_ff;
   assign rsp_fraction_q16  = out_frac_ff;
   assign rsp_pulse_total   = out_ptot_ff;
   assign rsp_freq_q8       = out_freq_ff;

   assign status.div_last      = cnt_ff == '0;
   assign status.out_free      = ~rsp_valid_ff | rsp_ready;
   assign status.relative_mode = relative_ff;
   assign status.count_enable  = count_en_ff;
   assign status.interval_zero = interval_ff == 32'd0;

endmodule

/* sv/pulse_high_time_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// pulse_high_time_accumulator_unit
// pin high time, duty fraction and pulse frequency over a polling interval
// ----------------------------------------------------------------------------
// A tick word (action 0) advances the microsecond timebase by one and samples
// the pin; ticks are accepted back to back while no poll is running. A poll
// word (action 1) reads and clears the accumulated high time and produces one
// response word. A poll walks the flag stage, then a pass of the shared
// restoring divider, which retires one quotient bit per cycle, for the duty
// fraction when relative mode is on and for the frequency when counting is on
// (each only with a nonzero interval), then the response load; no words are
// accepted during that time. The finished response sits in an output register,
// so ticks keep flowing while it waits to be taken. Register writes are accepted in any cycle.
// ----------------------------------------------------------------------------
module pulse_high_time_accumulator_unit import phta_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   phta_req_if.sink   req_port,
   phta_rsp_if.source rsp_port,
   phta_csr_if.sink   csr_port
);

   phta_cmd_type    cmd;
   phta_status_type status;

   // register writes never stall
   assign csr_port.ready = 1'b1;

   // sequencer: ticks in idle, polls walk flags, divider passes and load
   phta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_action (req_port.action),
      .req_ready  (req_port.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // timebase, accumulators, poll arithmetic and response register
   phta_dp #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pin_level     (req_port.pin_level),
      .csr_write         (csr_port.valid),
      .csr_index         (csr_port.index),
      .csr_data          (csr_port.data),
      .rsp_ready         (rsp_port.ready),
      .rsp_valid         (rsp_port.valid),
      .rsp_width_us      (rsp_port.width_us),
      .rsp_rejected      (rsp_port.rejected),
      .rsp_over_interval (rsp_port.over_interval),
      .rsp_fraction_q16  (rsp_port.fraction_q16),
      .rsp_pulse_total   (rsp_port.pulse_total),
      .rsp_freq_q8       (rsp_port.freq_q8)
   );

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for pulse_high_time_accumulator_unit: a cycle-free predictor works
// out the poll response of each accepted word, and every response word is
// compared with the oldest expectation while both channels idle and stall
// ----------------------------------------------------------------------------
module tb_top;
   import phta_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 140;     // outlasts the longest poll
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_SEND_GAP  = 6;
   localparam int REPORT_LIMIT  = 10;
   localparam int RUN_LIMIT     = 30000000;

   // indexes past the register list, writes there must change nothing
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   // one poll response as the block should report it
   typedef struct packed {
      logic [31:0] width_us;
      logic        rejected;
      logic        over_interval;
      logic [16:0] fraction_q16;
      logic [31:0] pulse_total;
      logic [31:0] freq_q8;
   } poll_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   phta_req_if req_bus ();
   phta_rsp_if rsp_bus ();
   phta_csr_if csr_bus ();

   pulse_high_time_accumulator_unit #(
      .TIME_WIDTH (TIME_WIDTH_DEFAULT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // predictor state: its own copy of the registers and the measurement state
   // --------------------------------------------------------------------------
   logic [31:0] cfg_interval;
   logic [31:0] cfg_reject_limit;
   logic [19:0] cfg_min_width;
   logic [31:0] cfg_split_age;
   logic        cfg_relative;
   logic        cfg_count_enable;

   logic [TIME_WIDTH_DEFAULT-1:0] timebase_us;
   logic [TIME_WIDTH_DEFAULT-1:0] rise_time_us;
   logic                          pin_prev;
   logic [31:0]                   high_time_total;
   logic [31:0]                   pulses_counted;

   poll_report_type pending_reports[$];

   // stimulus knobs, percent of cycles
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic receiver_hold  = 1'b0;

   // run bookkeeping
   int words_sent        = 0;
   int polls_sent        = 0;
   int settings_used     = 0;
   int responses_checked = 0;
   int mismatch_count    = 0;
   int unexpected_count  = 0;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? U32_MAX : sum[31:0];
   endfunction

   function automatic void apply_register(input csr_index_type idx, input logic [31:0] data);
      case (idx)
         CSR_INTERVAL:     cfg_interval     = data;
         CSR_REJECT_LIMIT: cfg_reject_limit = data;
         CSR_MIN_WIDTH:    cfg_min_width    = data[19:0];
         CSR_SPLIT_AGE:    cfg_split_age    = data;
         CSR_RELATIVE:     cfg_relative     = data[0];
         CSR_COUNT_ENABLE: cfg_count_enable = data[0];
         default: ;        // unused index, ignored
      endcase
   endfunction

   // advance the predictor by one accepted word; a poll queues its response
   function automatic void account_word(input logic action, input logic pin);
      logic [31:0]     pulse_len;
      logic [31:0]     age;
      logic [31:0]     total;
      logic [31:0]     tally;
      logic [63:0]     quot;
      poll_report_type rpt;
      if (action == ACTION_TICK) begin
         // time moves first, so an edge carries the new stamp
         timebase_us = timebase_us + 1'b1;
         if (pin && !pin_prev) begin
            rise_time_us = timebase_us;
         end else if (!pin && pin_prev) begin
            pulse_len = timebase_us - rise_time_us;
            if (pulse_len > 32'(cfg_min_width)) begin
               high_time_total = sat_add32(high_time_total, pulse_len);
               pulses_counted  = sat_add32(pulses_counted, 32'd1);
            end
         end
         pin_prev = pin;
      end else begin
         rpt   = '0;
         total = high_time_total;
         age   = timebase_us - rise_time_us;
         high_time_total = '0;
         // long pulse still high: bill the elapsed part to this poll
         if (age > cfg_split_age && pin) begin
            rise_time_us = timebase_us;
            total = sat_add32(total, age);
         end
         // flags judged before a rejected total is zeroed
         rpt.over_interval = (64'(total) * 64'(OVER_DEN)) > (64'(cfg_interval) * 64'(OVER_NUM));
         rpt.rejected      = total > cfg_reject_limit;
         if (rpt.rejected) begin
            total = '0;
         end
         rpt.width_us = total;
         if (cfg_relative) begin
            if (cfg_interval == '0) begin
               rpt.fraction_q16 = (total != '0) ? FRAC_ONE : '0;
            end else begin
               quot = (64'(total) << 16) / 64'(cfg_interval);
               rpt.fraction_q16 = (quot > 64'(FRAC_ONE)) ? FRAC_ONE : quot[16:0];
            end
         end
         if (cfg_count_enable) begin
            tally = pulses_counted;
            pulses_counted = '0;
            rpt.pulse_total = tally;
            if (cfg_interval == '0) begin
               rpt.freq_q8 = (tally != '0) ? U32_MAX : '0;
            end else begin
               quot = (64'(tally) * 64'(FREQ_SCALE)) / 64'(cfg_interval);
               rpt.freq_q8 = (quot > 64'(U32_MAX)) ? U32_MAX : quot[31:0];
            end
         end
         pending_reports.push_back(rpt);
      end
   endfunction

   // --------------------------------------------------------------------------
   // receiver: random stalls, or a long hold while pressure is applied
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_bus.ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // --------------------------------------------------------------------------
   // monitor: register writes and accepted words feed the predictor, response
   // words are checked against the oldest expectation
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      poll_report_type want;
      poll_report_type seen;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            apply_register(csr_bus.index, csr_bus.data);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.width_us      = rsp_bus.width_us;
            seen.rejected      = rsp_bus.rejected;
            seen.over_interval = rsp_bus.over_interval;
            seen.fraction_q16  = rsp_bus.fraction_q16;
            seen.pulse_total   = rsp_bus.pulse_total;
            seen.freq_q8       = rsp_bus.freq_q8;
            if (pending_reports.size() == 0) begin
               unexpected_count++;
               if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
                  $display("unexpected response word: width %0d pulses %0d freq %0d",
                           seen.width_us, seen.pulse_total, seen.freq_q8);
               end
            end else begin
               want = pending_reports.pop_front();
               responses_checked++;
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
                     $display("response %0d mismatch (expected / actual):", responses_checked);
                     $display("  width %0d / %0d  rejected %0b / %0b  over %0b / %0b",
                              want.width_us, seen.width_us, want.rejected, seen.rejected,
                              want.over_interval, seen.over_interval);
                     $display("  fraction %0d / %0d  pulses %0d / %0d  freq %0d / %0d",
                              want.fraction_q16, seen.fraction_q16, want.pulse_total,
                              seen.pulse_total, want.freq_q8, seen.freq_q8);
                  end
               end
            end
         end
         // predict after the check, a response never belongs to the word
         // accepted at the same edge
         if (req_bus.valid && req_bus.ready) begin
            account_word(req_bus.action, req_bus.pin_level);
         end
      end
   end

   // --------------------------------------------------------------------------
   // drivers; every task returns in the time step of a rising edge
   // --------------------------------------------------------------------------
   task automatic send_word(input logic action, input logic pin);
      req_bus.valid     <= 1'b1;
      req_bus.action    <= action;
      req_bus.pin_level <= pin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      if (action == ACTION_POLL) polls_sent++;
      // sender gap, valid stays up when the next word follows at once
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_SEND_GAP)) @(posedge clock);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] data,
                                 input bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (last) csr_bus.valid <= 1'b0;
   endtask

   // wait for every response, then let a poll still in the divider finish
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input logic [31:0] interval, input logic [31:0] reject,
                                    input logic [31:0] min_width, input logic [31:0] split,
                                    input logic [31:0] relative, input logic [31:0] counting,
                                    input bit add_spare);
      wait_drained();
      write_register(CSR_INTERVAL, interval, 1'b0);
      write_register(CSR_REJECT_LIMIT, reject, 1'b0);
      write_register(CSR_MIN_WIDTH, min_width, 1'b0);
      write_register(CSR_SPLIT_AGE, split, 1'b0);
      write_register(CSR_RELATIVE, relative, 1'b0);
      write_register(CSR_COUNT_ENABLE, counting, !add_spare);
      if (add_spare) begin
         write_register(CSR_SPARE_LO, $urandom, 1'b0);
         write_register(CSR_SPARE_HI, $urandom, 1'b1);
      end
      settings_used++;
   endtask

   // pin as alternating high and low runs with rare one-tick glitches, polls
   // mostly read the current level
   task automatic run_traffic(input int n_words, input int poll_pct,
                              input int max_high, input int max_low);
      logic pin_now;
      int   run_left;
      pin_now  = $urandom_range(1);
      run_left = $urandom_range(1, pin_now ? max_high : max_low);
      repeat (n_words) begin
         if ($urandom_range(99) < poll_pct) begin
            send_word(ACTION_POLL, ($urandom_range(9) == 0) ? !pin_now : pin_now);
         end else begin
            if (run_left == 0) begin
               pin_now  = !pin_now;
               run_left = $urandom_range(1, pin_now ? max_high : max_low);
            end
            run_left--;
            send_word(ACTION_TICK, ($urandom_range(99) == 0) ? !pin_now : pin_now);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------

   // register values straight out of reset, counting and relative mode off
   task automatic test_reset_defaults();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      settings_used++;
      run_traffic(30, 10, 40, 40);
   endtask

   // hand-built edges: counted, too short and exactly minimum pulses, a split
   // of a long high pulse at a poll and a poll too early to split
   task automatic test_directed_edges();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_registers(32'd1000, U32_MAX, 32'd2, 32'd5, 32'd1, 32'd1, 1'b1);
      send_word(ACTION_POLL, 1'b0);            // nothing gathered yet
      repeat (3) send_word(ACTION_TICK, 1'b1);
      send_word(ACTION_TICK, 1'b0);            // width 3, counted
      send_word(ACTION_TICK, 1'b1);
      send_word(ACTION_TICK, 1'b0);            // width 1, dropped
      repeat (2) send_word(ACTION_TICK, 1'b1);
      send_word(ACTION_TICK, 1'b0);            // width equal to minimum, dropped
      send_word(ACTION_POLL, 1'b0);
      repeat (8) send_word(ACTION_TICK, 1'b1);
      send_word(ACTION_POLL, 1'b1);            // old high pulse split here
      send_word(ACTION_TICK, 1'b1);
      send_word(ACTION_POLL, 1'b1);            // too young to split
      send_word(ACTION_TICK, 1'b0);
      send_word(ACTION_POLL, 1'b0);
      req_bus.valid <= 1'b0;
   endtask

   // all-ones registers: widest interval, no rejection, no pulse long enough
   task automatic test_registers_high();
      send_idle_pct  = 54;
      recv_stall_pct = 0;
      program_registers(U32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX, 1'b0);
      run_traffic(30, 10, 40, 40);
   endtask

   // smallest interval, every nonzero total rejected, every pulse counted, split at
   // every poll while high; relative bit written as zero under junk bits
   task automatic test_registers_low();
      send_idle_pct  = 0;
      recv_stall_pct = 54;
      program_registers(32'd1000, 32'd0, 32'hFFF0_0000, 32'd0,
                        $urandom & 32'hFFFF_FFFE, $urandom | 32'd1, 1'b0);
      run_traffic(40, 10, 30, 30);
   endtask

   task automatic test_random_registers();
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      repeat (2) begin
         program_registers($urandom_range(1000, 5000), $urandom_range(0, 400),
                           $urandom_range(0, 30), $urandom_range(0, 150),
                           $urandom, $urandom, 1'b0);
         run_traffic(30, 10, 30, 30);
      end
   endtask

   // zero interval: fraction and frequency go full scale on any activity
   task automatic test_zero_interval();
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      program_registers(32'd0, U32_MAX, $urandom_range(0, 5), $urandom_range(0, 50),
                        32'd1, 32'd1, 1'b0);
      run_traffic(30, 12, 20, 20);
   endtask

   // receiver holds off while polls keep coming: the response register fills
   // and the block has to stall its input
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      program_registers(32'd1000, $urandom_range(100, 2000), $urandom_range(0, 10),
                        $urandom_range(0, 60), 32'd1, 32'd1, 1'b0);
      fork
         begin
            receiver_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            receiver_hold = 1'b0;
         end
         run_traffic(60, 20, 30, 30);
      join
   endtask

   // mostly high for over a thousand microseconds: over-interval flag and a
   // clamped fraction against the smallest interval
   task automatic test_long_high_time();
      send_idle_pct  = 0;
      recv_stall_pct = 54;
      program_registers(32'd1000, U32_MAX, $urandom_range(0, 4), 32'd0, 32'd1, 32'd1, 1'b0);
      run_traffic(1150, 0, 80, 2);
      send_word(ACTION_POLL, 1'b1);
      req_bus.valid <= 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      cfg_interval     = INTERVAL_RESET;
      cfg_reject_limit = REJECT_LIMIT_RESET;
      cfg_min_width    = MIN_WIDTH_RESET;
      cfg_split_age    = SPLIT_AGE_RESET;
      cfg_relative     = 1'b0;
      cfg_count_enable = 1'b0;
      timebase_us      = '0;
      rise_time_us     = '0;
      pin_prev         = 1'b0;
      high_time_total  = '0;
      pulses_counted   = '0;

      req_bus.valid     = 1'b0;
      req_bus.action    = ACTION_TICK;
      req_bus.pin_level = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_INTERVAL;
      csr_bus.data      = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_edges();
      test_registers_high();
      test_registers_low();
      test_random_registers();
      test_zero_interval();
      test_backpressure();
      test_long_high_time();

      wait_drained();
      $display("covered %0d words (%0d polls) under %0d register settings", words_sent,
               polls_sent, settings_used);
      $display("checked %0d responses: %0d wrong, %0d unexpected, %0d missing",
               responses_checked, mismatch_count, unexpected_count, pending_reports.size());
      if (mismatch_count == 0 && unexpected_count == 0 && pending_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(RUN_LIMIT);
      $display("watchdog expired");
      $display("Test completed with failures");
      $finish;
   end

endmodule
